>>> sv/lfps_pkg.sv
package lfps_pkg;

  // Default parameter values
  localparam int SENSOR_COUNT_DEF    = 8;
  localparam int ERROR_FRAC_BITS_DEF = 8;

  // Register and field widths
  localparam int GAIN_W      = 8;
  localparam int SPEED_W     = 10;
  localparam int TICK_W      = 8;
  localparam int SCALE_W     = 16;
  localparam int TURN_OUT_W  = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  // Turn limit numerator is speed * LIM_K
  localparam int LIM_K       = 800;
  localparam int LIM_NUM_W   = SPEED_W + $clog2(LIM_K + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_STOP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_INVERT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = 8'd40;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST     = 8'd10;
  localparam logic [SPEED_W-1:0] FULL_SPEED_RST     = 10'd120;
  localparam logic [SPEED_W-1:0] RECOVERY_SPEED_RST = 10'd36;
  localparam logic [TICK_W-1:0]  LOST_STOP_RST      = 8'd3;
  localparam logic               STEER_INVERT_RST   = 1'b1;
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST    = 16'd800;

endpackage

>>> sv/lfps_div.sv
module lfps_div import lfps_pkg::*; #(
  parameter int N_W = LIM_NUM_W,
  parameter int D_W = SCALE_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   quo_q;
  logic [D_W-1:0]   rem_q;
  logic [D_W-1:0]   divs_q;

  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit, try a subtract
  assign shifted = {rem_q, quo_q[N_W-1]};
  assign trial   = shifted - {1'b0, divs_q};
  assign fits    = (shifted >= {1'b0, divs_q});

  // Sequencer: N_W steps, done pulses for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      divs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N_W-2:0], fits};
      rem_q <= fits ? trial[D_W-1:0] : shifted[D_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> sv/line_follow_pd_steering_top.sv
// Line-follow PD steering controller. Each input word is one sensor mask;
// each produces exactly one output word (speed, turn, stopped, line_seen).
// Items are processed one at a time; in_stall_o is high while an item is in
// work. A shared bit-serial divider, one quotient bit per cycle, forms the
// mean sensor position when the line is seen and then the turn limit unless
// the item stops; its quotient width is 20 at default parameters. One shared
// multiplier forms the P term and, when the line is seen, adds the D term.
// A finished word sits in the output register while the next mask may
// already be accepted.
module line_follow_pd_steering_top import lfps_pkg::*; #(
  parameter int SENSOR_COUNT    = SENSOR_COUNT_DEF,
  parameter int ERROR_FRAC_BITS = ERROR_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [SENSOR_COUNT-1:0]      black_mask_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [SPEED_W-1:0]           drive_speed_o,
  output logic signed [TURN_OUT_W-1:0] turn_cmd_o,
  output logic                         stopped_o,
  output logic                         line_seen_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int IDX_W     = $clog2(SENSOR_COUNT);
  localparam int CNT_W     = $clog2(SENSOR_COUNT + 1);
  localparam int SUM_MAG_W = $clog2(SENSOR_COUNT * SENSOR_COUNT / 4 + 1);
  localparam int SUM_W     = SUM_MAG_W + 1;
  localparam int ERR_W     = $clog2(SENSOR_COUNT) + ERROR_FRAC_BITS + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int PROD_W    = DIFF_W + GAIN_W + 1;
  localparam int PD_W      = PROD_W + 1;
  localparam int TURN_W    = PD_W - ERROR_FRAC_BITS;
  localparam int EDIV_W    = SUM_MAG_W + ERROR_FRAC_BITS;
  localparam int DIV_N_W   = (EDIV_W > LIM_NUM_W) ? EDIV_W : LIM_NUM_W;
  localparam int CMP_W     = ((TURN_W > LIM_NUM_W) ? TURN_W : LIM_NUM_W) + 2;
  localparam int BAND_W    = (SUM_MAG_W > CNT_W + 2) ? SUM_MAG_W : CNT_W + 2;

  localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(SENSOR_COUNT - 1);
  localparam logic [SUM_W-1:0]       WT_OFFSET = SUM_W'(SENSOR_COUNT - 1);
  localparam logic signed [PD_W-1:0] FRAC_MASK = PD_W'((1 << ERROR_FRAC_BITS) - 1);
  localparam logic signed [CMP_W-1:0] SAT_HI   = CMP_W'((1 << (TURN_OUT_W - 1)) - 1);
  localparam logic signed [CMP_W-1:0] SAT_LO   = -SAT_HI - CMP_W'(1);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_CLASS = 4'd2;
  localparam logic [3:0] S_EDIV  = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_LDIV  = 4'd6;
  localparam logic [3:0] S_LDIVW = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  // Configuration registers
  logic [GAIN_W-1:0]  prop_gain_q;
  logic [GAIN_W-1:0]  deriv_gain_q;
  logic [SPEED_W-1:0] full_speed_q;
  logic [SPEED_W-1:0] recovery_speed_q;
  logic [TICK_W-1:0]  lost_stop_ticks_q;
  logic               steer_invert_q;
  logic [SCALE_W-1:0] speed_scale_q;

  // Control state
  logic [3:0]              state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  logic [TICK_W-1:0]       lost_q, lost_d;
  logic signed [ERR_W-1:0] prev_err_q, prev_err_d;

  // Working registers
  logic [SENSOR_COUNT-1:0]  mask_q, mask_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [SPEED_W-1:0]       speed_q, speed_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [PD_W-1:0]   acc_q, acc_d;
  logic signed [TURN_W-1:0] turn_q, turn_d;
  logic                     seen_q, seen_d;
  logic                     stop_q, stop_d;
  logic [SPEED_W-1:0]           drive_speed_q, drive_speed_d;
  logic signed [TURN_OUT_W-1:0] turn_cmd_q, turn_cmd_d;
  logic                         stopped_q, stopped_d;
  logic                         line_seen_q, line_seen_d;

  // Handshakes
  logic in_acc;
  logic out_acc;
  logic out_free;

  // Divider hookup
  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [SCALE_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quot;

  // Datapath nets
  logic [SUM_W-1:0]          weight;
  logic signed [SUM_W-1:0]   sum_abs;
  logic [SUM_MAG_W-1:0]      sum_mag;
  logic [BAND_W-1:0]         mag_x;
  logic [BAND_W-1:0]         cnt1_x;
  logic [BAND_W-1:0]         cnt3_x;
  logic [SPEED_W+1:0]        full3;
  logic [SPEED_W-1:0]        band_speed;
  logic [TICK_W-1:0]         lost_inc;
  logic signed [ERR_W-1:0]   emag;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [GAIN_W:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PD_W-1:0]    pd_v;
  logic signed [PD_W-1:0]    pd_adj;
  logic signed [PD_W-1:0]    pd_shr;
  logic [LIM_NUM_W-1:0]      lim_num;
  logic [LIM_NUM_W-1:0]      lim;
  logic signed [CMP_W-1:0]   turn_x;
  logic signed [CMP_W-1:0]   lim_x;
  logic signed [CMP_W-1:0]   clamp;
  logic signed [CMP_W-1:0]   sat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Sensor weight 2*i - (N-1)
  assign weight = SUM_W'({idx_q, 1'b0}) - WT_OFFSET;

  // Speed band from |sum| against count and 3*count
  assign sum_abs    = sum_q[SUM_W-1] ? -sum_q : sum_q;
  assign sum_mag    = sum_abs[SUM_MAG_W-1:0];
  assign mag_x      = BAND_W'(sum_mag);
  assign cnt1_x     = BAND_W'(cnt_q);
  assign cnt3_x     = cnt1_x + {cnt1_x[BAND_W-2:0], 1'b0};
  assign full3      = {2'b00, full_speed_q} + {1'b0, full_speed_q, 1'b0};
  assign band_speed = (mag_x > cnt3_x) ? (full_speed_q >> 1) :
                      (mag_x > cnt1_x) ? full3[SPEED_W+1:2] : full_speed_q;

  assign lost_inc = (lost_q == '1) ? lost_q : lost_q + 1'b1;

  // Mean position magnitude from the divider
  assign emag = signed'({1'b0, div_quot[ERR_W-2:0]});

  // Shared multiplier: error (previous error while the line is lost) * P gain, then error change * D gain
  assign diff  = DIFF_W'(err_q) - DIFF_W'(prev_err_q);
  assign mul_a = (state_q == S_MUL2) ? diff :
                 (seen_q ? DIFF_W'(err_q) : DIFF_W'(prev_err_q));
  assign mul_b = signed'({1'b0, (state_q == S_MUL2) ? deriv_gain_q : prop_gain_q});
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Optional negation, then drop fraction bits toward zero
  assign pd_v   = steer_invert_q ? -acc_q : acc_q;
  assign pd_adj = pd_v + (pd_v[PD_W-1] ? FRAC_MASK : PD_W'(0));
  assign pd_shr = pd_adj >>> ERROR_FRAC_BITS;

  // Turn limit numerator
  assign lim_num = LIM_NUM_W'(speed_q) * LIM_NUM_W'(LIM_K);

  // Clamp to +-limit, then saturate to the output width
  assign lim    = div_quot[LIM_NUM_W-1:0];
  assign turn_x = CMP_W'(turn_q);
  assign lim_x  = signed'(CMP_W'(lim));
  assign clamp  = (turn_x > lim_x)  ? lim_x :
                  (turn_x < -lim_x) ? -lim_x : turn_x;
  assign sat    = (clamp > SAT_HI) ? SAT_HI :
                  (clamp < SAT_LO) ? SAT_LO : clamp;

  // Sequencer and next-state logic
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    lost_d        = lost_q;
    prev_err_d    = prev_err_q;
    mask_d        = mask_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    sum_d         = sum_q;
    speed_d       = speed_q;
    err_d         = err_q;
    acc_d         = acc_q;
    turn_d        = turn_q;
    seen_d        = seen_q;
    stop_d        = stop_q;
    drive_speed_d = drive_speed_q;
    turn_cmd_d    = turn_cmd_q;
    stopped_d     = stopped_q;
    line_seen_d   = line_seen_q;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mask_d  = black_mask_i;
          idx_d   = '0;
          cnt_d   = '0;
          sum_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mask_q[idx_q]) begin
          sum_d = sum_q + signed'(weight);
          cnt_d = cnt_q + 1'b1;
        end
        if (idx_q == LAST_IDX) begin
          state_d = S_CLASS;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_CLASS: begin
        if (cnt_q == '0) begin
          // Line lost: count up, then recover or stop
          seen_d = 1'b0;
          lost_d = lost_inc;
          if (lost_inc >= lost_stop_ticks_q) begin
            stop_d  = 1'b1;
            state_d = S_FIN;
          end else begin
            stop_d  = 1'b0;
            speed_d = recovery_speed_q;
            state_d = S_MUL1;
          end
        end else begin
          seen_d       = 1'b1;
          stop_d       = 1'b0;
          lost_d       = '0;
          speed_d      = band_speed;
          div_start    = 1'b1;
          div_dividend = DIV_N_W'({sum_mag, {ERROR_FRAC_BITS{1'b0}}});
          div_divisor  = SCALE_W'(cnt_q);
          state_d      = S_EDIV;
        end
      end
      S_EDIV: begin
        if (div_done) begin
          err_d   = sum_q[SUM_W-1] ? -emag : emag;
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        acc_d   = PD_W'(prod);
        state_d = seen_q ? S_MUL2 : S_LDIV;
      end
      S_MUL2: begin
        acc_d      = acc_q + PD_W'(prod);
        prev_err_d = err_q;
        state_d    = S_LDIV;
      end
      S_LDIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(lim_num);
        div_divisor  = (speed_scale_q == '0) ? SCALE_W'(1) : speed_scale_q;
        turn_d       = pd_shr[TURN_W-1:0];
        state_d      = S_LDIVW;
      end
      S_LDIVW: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          line_seen_d = seen_q;
          stopped_d   = stop_q;
          if (stop_q) begin
            drive_speed_d = '0;
            turn_cmd_d    = '0;
          end else begin
            drive_speed_d = speed_q;
            turn_cmd_d    = sat[TURN_OUT_W-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      out_valid_q       <= 1'b0;
      lost_q            <= '0;
      prev_err_q        <= '0;
      prop_gain_q       <= PROP_GAIN_RST;
      deriv_gain_q      <= DERIV_GAIN_RST;
      full_speed_q      <= FULL_SPEED_RST;
      recovery_speed_q  <= RECOVERY_SPEED_RST;
      lost_stop_ticks_q <= LOST_STOP_RST;
      steer_invert_q    <= STEER_INVERT_RST;
      speed_scale_q     <= SPEED_SCALE_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lost_q      <= lost_d;
      prev_err_q  <= prev_err_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PROP_GAIN:      prop_gain_q       <= cfg_data_i[GAIN_W-1:0];
          CFG_DERIV_GAIN:     deriv_gain_q      <= cfg_data_i[GAIN_W-1:0];
          CFG_FULL_SPEED:     full_speed_q      <= cfg_data_i[SPEED_W-1:0];
          CFG_RECOVERY_SPEED: recovery_speed_q  <= cfg_data_i[SPEED_W-1:0];
          CFG_LOST_STOP:      lost_stop_ticks_q <= cfg_data_i[TICK_W-1:0];
          CFG_STEER_INVERT:   steer_invert_q    <= cfg_data_i[0];
          CFG_SPEED_SCALE:    speed_scale_q     <= cfg_data_i[SCALE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    mask_q        <= mask_d;
    idx_q         <= idx_d;
    cnt_q         <= cnt_d;
    sum_q         <= sum_d;
    speed_q       <= speed_d;
    err_q         <= err_d;
    acc_q         <= acc_d;
    turn_q        <= turn_d;
    seen_q        <= seen_d;
    stop_q        <= stop_d;
    drive_speed_q <= drive_speed_d;
    turn_cmd_q    <= turn_cmd_d;
    stopped_q     <= stopped_d;
    line_seen_q   <= line_seen_d;
  end

  // Shared divider: mean position, then turn limit
  lfps_div #(
    .N_W (DIV_N_W),
    .D_W (SCALE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o   = out_valid_q;
  assign drive_speed_o = drive_speed_q;
  assign turn_cmd_o    = turn_cmd_q;
  assign stopped_o     = stopped_q;
  assign line_seen_o   = line_seen_q;

`ifndef SYNTHESIS
  a_stop_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_o |-> drive_speed_o == '0 && turn_cmd_o == '0 && !line_seen_o)
    else $error("stop word carries speed, turn or line_seen");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_EDIV || state_q == S_LDIVW))
    else $error("divider finished outside a wait state");

  a_seen_clears_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && seen_q |-> lost_q == '0)
    else $error("lost counter not cleared with line in view");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_SCAN)
    else $error("accepted mask did not start a scan");
`endif

endmodule
